// ===== hdl/pretrigger_capture_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine assertion macros
// Shared concurrent assertion wrappers; ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef PRETRIGGER_CAPTURE_ENGINE_DEFINES_SVH
`define PRETRIGGER_CAPTURE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define PCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pretrigger capture engine: implication check failed");

// Antecedent implies consequent in the next cycle.
`define PCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pretrigger capture engine: next-cycle check failed");

`else

`define PCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine package
// Shared constants, entry, command and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pce_pkg;

    localparam int CAPTURE_DEPTH = 1024;
    localparam int PRE_DEPTH     = 20;
    localparam int COPY_N        = (PRE_DEPTH < CAPTURE_DEPTH) ? PRE_DEPTH : CAPTURE_DEPTH;

    localparam int ADDR_W  = $clog2(CAPTURE_DEPTH);
    localparam int COUNT_W = $clog2(CAPTURE_DEPTH + 1);
    localparam int RING_W  = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
    localparam int CPY_W   = (COPY_N > 1) ? $clog2(COPY_N) : 1;

    localparam int LEVEL_W = 8;
    localparam int GAP_W   = 16;
    localparam int IDX_W   = 10;
    localparam int ENTRY_W = 11;
    localparam int HOLD_W  = 20;
    localparam int SUM_W   = 21;
    localparam int CMP_W   = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

    localparam logic [LEVEL_W-1:0] THRESH_RESET = LEVEL_W'(43);
    localparam logic [HOLD_W-1:0]  HOLD_RESET   = HOLD_W'(20000);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_READ   = 2'd1,
        OP_FROZEN = 2'd2
    } op_t;

    typedef struct packed {
        logic [GAP_W-1:0]   gap_us;
        logic               press_right;
        logic               press_left;
        logic [LEVEL_W-1:0] level_right;
        logic [LEVEL_W-1:0] level_left;
    } entry_t;

    typedef struct packed {
        op_t              kind;
        entry_t           entry;
        logic [IDX_W-1:0] read_index;
        logic             trig_left;
        logic             trig_right;
        logic             rel_left;
        logic             rel_right;
    } cmd_t;

    typedef struct packed {
        logic               capturing;
        logic               capture_ready;
        logic               side_right;
        logic [ENTRY_W-1:0] entry_count;
        logic               read_valid;
        entry_t             entry;
    } res_t;

endpackage

// ===== hdl/pce_front.sv =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine front end
// Decodes an incoming beat and precomputes trigger and release flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pce_front (
    input  logic                       cmd,
    input  logic                       freeze,
    input  logic [7:0]                 level_left,
    input  logic [7:0]                 level_right,
    input  logic                       press_left,
    input  logic                       press_right,
    input  logic [15:0]                gap_us,
    input  logic [9:0]                 read_index,
    input  logic [pce_pkg::LEVEL_W-1:0] threshold,
    output pce_pkg::cmd_t              item
);
    import pce_pkg::*;

    logic hi_left;
    logic hi_right;

    assign hi_left  = (level_left >= threshold) || press_left;
    assign hi_right = (level_right >= threshold) || press_right;

    always_comb
    begin
        if (cmd)
            item.kind = OP_READ;
        else if (freeze)
            item.kind = OP_FROZEN;
        else
            item.kind = OP_SAMPLE;
        item.entry.level_left  = level_left;
        item.entry.level_right = level_right;
        item.entry.press_left  = press_left;
        item.entry.press_right = press_right;
        item.entry.gap_us      = gap_us;
        item.read_index        = read_index;
        item.trig_left         = hi_left;
        item.trig_right        = hi_right;
        item.rel_left          = !hi_left;
        item.rel_right         = !hi_right;
    end

endmodule

// ===== hdl/pce_queue.sv =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine command queue
// Short FIFO of decoded commands between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pce_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  pce_pkg::cmd_t wr_item,
    output logic          full,
    input  logic          rd_en,
    output pce_pkg::cmd_t rd_item,
    output logic          not_empty
);
    import pce_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = slot_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + Q_PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + Q_PTR_W'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + Q_CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// ===== hdl/pce_back.sv =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine back end
// Capture state machine, pre-trigger ring, capture memory, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pretrigger_capture_engine_defines.svh"

module pce_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  pce_pkg::cmd_t              q_item,
    output logic                       q_pop,
    input  logic [pce_pkg::HOLD_W-1:0] hold,
    input  logic                       pop,
    output logic                       empty,
    output pce_pkg::res_t              result
);
    import pce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_COPY = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    entry_t             ring_reg [PRE_DEPTH];
    logic [RING_W-1:0]  ring_pos_reg, ring_pos_next;
    logic [RING_W-1:0]  src_reg, src_next;
    logic [CPY_W-1:0]   copy_cnt_reg, copy_cnt_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic               active_reg, active_next;
    logic               ready_reg, ready_next;
    logic               right_reg, right_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               rvalid_reg, rvalid_next;
    logic               res_valid_reg;
    res_t               res_reg;

    entry_t             mem [CAPTURE_DEPTH];
    entry_t             rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic               ring_we;
    logic               res_load;
    res_t               res_data;
    logic               slot_free;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               released;
    logic               full_now;
    logic               not_full;

    assign slot_free = !res_valid_reg || pop;
    assign empty     = !res_valid_reg;
    assign result    = res_reg;

    assign not_full = (fill_reg != COUNT_W'(CAPTURE_DEPTH));
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(q_item.entry.gap_us);
    assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign released = right_reg ? q_item.rel_right : q_item.rel_left;
    assign full_now = not_full ? (fill_reg + COUNT_W'(1) == COUNT_W'(CAPTURE_DEPTH)) : 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        ring_pos_next = ring_pos_reg;
        src_next      = src_reg;
        copy_cnt_next = copy_cnt_reg;
        fill_next     = fill_reg;
        active_next   = active_reg;
        ready_next    = ready_reg;
        right_next    = right_reg;
        sum_next      = sum_reg;
        rvalid_next   = rvalid_reg;
        q_pop         = 1'b0;
        ring_we       = 1'b0;
        res_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = ADDR_W'(copy_cnt_reg);
        mem_wdata     = ring_reg[src_reg];
        mem_re        = 1'b0;
        mem_raddr     = ADDR_W'(q_item.read_index);

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        OP_READ:
                        begin
                            rvalid_next = CMP_W'(q_item.read_index) < CMP_W'(fill_reg);
                            mem_re      = 1'b1;
                            state_next  = S_READ;
                        end
                        OP_FROZEN:
                        begin
                            res_load = 1'b1;
                        end
                        OP_SAMPLE:
                        begin
                            if (active_reg)
                            begin
                                // append, then check buffer full / release hold
                                if (not_full)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = fill_reg[ADDR_W-1:0];
                                    mem_wdata = q_item.entry;
                                    fill_next = fill_reg + COUNT_W'(1);
                                end
                                if (released || full_now)
                                begin
                                    if ((sum_sat >= SUM_W'(hold)) || full_now)
                                    begin
                                        active_next = 1'b0;
                                        ready_next  = 1'b1;
                                        sum_next    = '0;
                                    end
                                    else
                                        sum_next = sum_sat;
                                end
                                else
                                    sum_next = '0;
                                res_load = 1'b1;
                            end
                            else
                            begin
                                ring_we       = 1'b1;
                                ring_pos_next = (ring_pos_reg == RING_W'(PRE_DEPTH - 1)) ? '0
                                              : ring_pos_reg + RING_W'(1);
                                if (q_item.trig_left || q_item.trig_right)
                                begin
                                    right_next    = !q_item.trig_left;
                                    src_next      = ring_pos_next;
                                    copy_cnt_next = '0;
                                    state_next    = S_COPY;
                                end
                                else
                                    res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                // ring to capture memory, oldest first, first gap cleared
                mem_we = 1'b1;
                if (copy_cnt_reg == '0)
                    mem_wdata.gap_us = '0;
                src_next      = (src_reg == RING_W'(PRE_DEPTH - 1)) ? '0 : src_reg + RING_W'(1);
                copy_cnt_next = copy_cnt_reg + CPY_W'(1);
                if (copy_cnt_reg == CPY_W'(COPY_N - 1))
                begin
                    fill_next   = COUNT_W'(COPY_N);
                    ready_next  = 1'b0;
                    active_next = 1'b1;
                    sum_next    = '0;
                    res_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_data.capturing     = active_next;
        res_data.capture_ready = ready_next;
        res_data.side_right    = right_next;
        res_data.entry_count   = ENTRY_W'(fill_next);
        res_data.read_valid    = (state_reg == S_READ) && rvalid_reg;
        res_data.entry         = res_data.read_valid ? rd_data_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ring_pos_reg  <= '0;
            src_reg       <= '0;
            copy_cnt_reg  <= '0;
            fill_reg      <= '0;
            active_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            right_reg     <= 1'b0;
            sum_reg       <= '0;
            rvalid_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < PRE_DEPTH; i++)
                ring_reg[i] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ring_pos_reg <= ring_pos_next;
            src_reg      <= src_next;
            copy_cnt_reg <= copy_cnt_next;
            fill_reg     <= fill_next;
            active_reg   <= active_next;
            ready_reg    <= ready_next;
            right_reg    <= right_next;
            sum_reg      <= sum_next;
            rvalid_reg   <= rvalid_next;
            if (ring_we)
                ring_reg[ring_pos_reg] <= q_item.entry;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_data;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    `PCE_ASSERT_IMPLY(a_act_not_rdy, clk, rst_n, active_reg, !ready_reg)
    `PCE_ASSERT_IMPLY(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= COUNT_W'(CAPTURE_DEPTH))
    `PCE_ASSERT_IMPLY(a_sum_idle_zero, clk, rst_n, !active_reg, sum_reg == '0)
    `PCE_ASSERT_IMPLY(a_copy_slot_free, clk, rst_n, state_reg == S_COPY, !res_valid_reg)
    `PCE_ASSERT_NEXT(a_read_result, clk, rst_n, state_reg == S_READ, res_valid_reg)

endmodule

// ===== hdl/pretrigger_capture_engine.sv =====
// Flow: beats pass through the command queue; frozen and non-triggering samples load the result
//   register from the decision, reads load it after S_READ, and a trigger after S_COPY.
// Throughput: one beat per cycle for plain samples while the result register is free; reads hold
//   the back end in S_READ, a trigger in S_COPY for the 20-entry pre-trigger copy, one per cycle.
// Reset: asynchronous, active low; clears status, ring and queue; capture memory is not
//   cleared and needs no clearing pass, so the block is ready right after reset.
// ----------------------------------------------------------------------------
// Pretrigger capture engine
// Pre-trigger ring with triggered capture of controller trigger samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pretrigger_capture_engine (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // input side: queue-style push
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic        freeze,
    input  logic [7:0]  level_left,
    input  logic [7:0]  level_right,
    input  logic        press_left,
    input  logic        press_right,
    input  logic [15:0] gap_us,
    input  logic [9:0]  read_index,
    // result side: queue-style pop
    output logic        empty,
    input  logic        pop,
    output logic        capturing,
    output logic        capture_ready,
    output logic        side_right,
    output logic [10:0] entry_count,
    output logic        read_valid,
    output logic [7:0]  out_level_left,
    output logic [7:0]  out_level_right,
    output logic        out_press_left,
    output logic        out_press_right,
    output logic [15:0] out_gap_us
);
    import pce_pkg::*;

    typedef enum logic [0:0] {
        REG_LEVEL_THRESHOLD = 1'b0,
        REG_RELEASE_HOLD    = 1'b1
    } cfg_reg_t;

    logic [LEVEL_W-1:0] threshold_reg;
    logic [HOLD_W-1:0]  hold_reg;

    cmd_t front_item;
    cmd_t q_item;
    logic q_valid;
    logic q_pop;
    res_t res;

    // Config writes are always taken; software must write only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEVEL_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE_HOLD:    hold_reg      <= cfg_data[HOLD_W-1:0];
                default:             ;
            endcase
        end
    end

    // Front end: classify the beat (read / frozen / sample) and precompute
    // the per-side trigger and release tests against the threshold.
    pce_front u_front (
        .cmd         (cmd),
        .freeze      (freeze),
        .level_left  (level_left),
        .level_right (level_right),
        .press_left  (press_left),
        .press_right (press_right),
        .gap_us      (gap_us),
        .read_index  (read_index),
        .threshold   (threshold_reg),
        .item        (front_item)
    );

    // Decoupling queue: the front keeps accepting while the back end copies
    // the ring or waits on a full result register, until the queue itself fills.
    pce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push),
        .wr_item   (front_item),
        .full      (full),
        .rd_en     (q_pop),
        .rd_item   (q_item),
        .not_empty (q_valid)
    );

    // Back end: capture state, ring, capture memory and the result register.
    pce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .hold    (hold_reg),
        .pop     (pop),
        .empty   (empty),
        .result  (res)
    );

    assign capturing       = res.capturing;
    assign capture_ready   = res.capture_ready;
    assign side_right      = res.side_right;
    assign entry_count     = res.entry_count;
    assign read_valid      = res.read_valid;
    assign out_level_left  = res.entry.level_left;
    assign out_level_right = res.entry.level_right;
    assign out_press_left  = res.entry.press_left;
    assign out_press_right = res.entry.press_right;
    assign out_gap_us      = res.entry.gap_us;

endmodule

// ===== bench/pretrigger_capture_engine_test.sv =====
// ----------------------------------------------------------------------------
// Pretrigger capture engine regression bench
// Drives sample and read beats through the push/full queue port, keeps a
// cycle-free shadow of the ring, the capture store and the release timer,
// and checks every popped status beat against the shadow in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pretrigger_capture_engine_test;

    import pce_pkg::*;

    // Command codes carried on the cmd port.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Register indexes on the cfg channel.
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_HOLD      = 1'b1
    } reg_sel_t;

    localparam int unsigned SUM_CEIL = (1 << SUM_W) - 1;
    // A trigger holds the back end for the ring copy; give the block slack on top.
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int LIMIT_CYCLES = 600000;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // Shadow of the capture engine: ring, store, status and release timer.
    // accept_beat() works out the status beat each accepted input causes,
    // check_status() compares each popped beat with the oldest one due.
    // ------------------------------------------------------------------------
    class capture_shadow;
        entry_t             ring [PRE_DEPTH];
        int                 ring_pos;
        entry_t             store [CAPTURE_DEPTH];
        int                 fill_count;
        bit                 active;
        bit                 done;
        bit                 right;
        int unsigned        hold_sum;
        logic [LEVEL_W-1:0] thr;
        logic [HOLD_W-1:0]  hold;
        res_t               status_due [$];
        int                 faults;

        function new();
            foreach (ring[i]) ring[i] = '0;
            foreach (store[i]) store[i] = '0;
            ring_pos   = 0;
            fill_count = 0;
            active     = 1'b0;
            done       = 1'b0;
            right      = 1'b0;
            hold_sum   = 0;
            thr        = THRESH_RESET;
            hold       = HOLD_RESET;
            faults     = 0;
        endfunction

        function void write_reg(reg_sel_t sel, logic [HOLD_W-1:0] val);
            if (sel == REG_THRESHOLD)
                thr = val[LEVEL_W-1:0];
            else
                hold = val;
        endfunction

        // Ring is copied oldest first; the oldest entry loses its gap.
        function void open_capture(bit side);
            entry_t e;
            right = side;
            for (int i = 0; i < COPY_N; i++)
            begin
                e = ring[(ring_pos + i) % PRE_DEPTH];
                if (i == 0)
                    e.gap_us = '0;
                store[i] = e;
            end
            fill_count = COPY_N;
            done       = 1'b0;
            active     = 1'b1;
            hold_sum   = 0;
        endfunction

        function void accept_beat(logic c, logic frz, entry_t e, logic [IDX_W-1:0] idx);
            res_t r;
            bit   released;
            bit   full_now;
            r = '0;
            if (c == CMD_READ)
            begin
                if (idx < fill_count)
                begin
                    r.read_valid = 1'b1;
                    r.entry      = store[idx];
                end
            end
            else if (!frz)
            begin
                if (active)
                begin
                    if (fill_count < CAPTURE_DEPTH)
                    begin
                        store[fill_count] = e;
                        fill_count++;
                    end
                    full_now = fill_count >= CAPTURE_DEPTH;
                    if (right)
                        released = e.level_right < thr && !e.press_right;
                    else
                        released = e.level_left < thr && !e.press_left;
                    if (released || full_now)
                    begin
                        hold_sum += e.gap_us;
                        if (hold_sum > SUM_CEIL)
                            hold_sum = SUM_CEIL;
                        if (hold_sum >= hold || full_now)
                        begin
                            active   = 1'b0;
                            done     = 1'b1;
                            hold_sum = 0;
                        end
                    end
                    else
                    begin
                        hold_sum = 0;
                    end
                end
                else
                begin
                    ring[ring_pos] = e;
                    ring_pos = (ring_pos + 1) % PRE_DEPTH;
                    if (e.level_left >= thr || e.press_left)
                        open_capture(1'b0);
                    else if (e.level_right >= thr || e.press_right)
                        open_capture(1'b1);
                end
            end
            r.capturing     = active;
            r.capture_ready = done;
            r.side_right    = right;
            r.entry_count   = ENTRY_W'(fill_count);
            status_due.push_back(r);
        endfunction

        function string describe(res_t r);
            return $sformatf("cap=%0b rdy=%0b side=%0b cnt=%0d rv=%0b L=%0d R=%0d pl=%0b pr=%0b gap=%0d",
                r.capturing, r.capture_ready, r.side_right, r.entry_count, r.read_valid,
                r.entry.level_left, r.entry.level_right, r.entry.press_left,
                r.entry.press_right, r.entry.gap_us);
        endfunction

        function void check_status(res_t got);
            res_t want;
            if (status_due.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("status beat with nothing due: %s", describe(got));
                return;
            end
            want = status_due.pop_front();
            if (got !== want)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("status mismatch want %s", describe(want));
                    $display("                got  %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [19:0] cfg_data;
    logic        push;
    logic        full;
    logic        cmd;
    logic        freeze;
    logic [7:0]  level_left;
    logic [7:0]  level_right;
    logic        press_left;
    logic        press_right;
    logic [15:0] gap_us;
    logic [9:0]  read_index;
    logic        empty;
    logic        pop;
    logic        capturing;
    logic        capture_ready;
    logic        side_right;
    logic [10:0] entry_count;
    logic        read_valid;
    logic [7:0]  out_level_left;
    logic [7:0]  out_level_right;
    logic        out_press_left;
    logic        out_press_right;
    logic [15:0] out_gap_us;

    pretrigger_capture_engine dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .cmd             (cmd),
        .freeze          (freeze),
        .level_left      (level_left),
        .level_right     (level_right),
        .press_left      (press_left),
        .press_right     (press_right),
        .gap_us          (gap_us),
        .read_index      (read_index),
        .empty           (empty),
        .pop             (pop),
        .capturing       (capturing),
        .capture_ready   (capture_ready),
        .side_right      (side_right),
        .entry_count     (entry_count),
        .read_valid      (read_valid),
        .out_level_left  (out_level_left),
        .out_level_right (out_level_right),
        .out_press_left  (out_press_left),
        .out_press_right (out_press_right),
        .out_gap_us      (out_gap_us)
    );

    capture_shadow board = new();

    // calm: neither side idles (one long stretch of back-to-back beats).
    // hold_off_req: asks the pop side for one long stall.
    bit   calm;
    bit   hold_off_req;
    int   live_beats;
    int   cycles;
    res_t seen_status;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Monitor: all handshakes are judged on pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(reg_sel_t'(cfg_index), cfg_data);
            if (push && !full)
                board.accept_beat(cmd, freeze,
                    make_entry(level_left, level_right, press_left, press_right, gap_us),
                    read_index);
            if (pop && !empty)
            begin
                seen_status.capturing         = capturing;
                seen_status.capture_ready     = capture_ready;
                seen_status.side_right        = side_right;
                seen_status.entry_count       = entry_count;
                seen_status.read_valid        = read_valid;
                seen_status.entry.level_left  = out_level_left;
                seen_status.entry.level_right = out_level_right;
                seen_status.entry.press_left  = out_press_left;
                seen_status.entry.press_right = out_press_right;
                seen_status.entry.gap_us      = out_gap_us;
                board.check_status(seen_status);
            end
        end
    end

    // Pop side: random stalls, none while calm, and one long hold-off on
    // request so the block backs up and raises full.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                pop <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------------
    function automatic entry_t make_entry(logic [7:0] ll, logic [7:0] lr, logic pl,
                                          logic pr, logic [15:0] g);
        entry_t e;
        e.level_left  = ll;
        e.level_right = lr;
        e.press_left  = pl;
        e.press_right = pr;
        e.gap_us      = g;
        return e;
    endfunction

    function automatic entry_t any_entry();
        return make_entry($urandom_range(255), $urandom_range(255), $urandom_range(1),
                          $urandom_range(1), $urandom_range(65535));
    endfunction

    // Gaps lean on the extremes and on short values.
    function automatic logic [15:0] pick_gap();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 16'd0;
        else if (roll == 1)
            return 16'hFFFF;
        else if (roll < 4)
            return $urandom_range(255);
        else
            return $urandom_range(65535);
    endfunction

    // Below threshold; with a zero threshold no level is quiet.
    function automatic logic [7:0] quiet_level();
        if (board.thr == 0)
            return 8'd0;
        return $urandom_range(0, board.thr - 1);
    endfunction

    // One side engaged (level at threshold or press) or quiet, the other random.
    function automatic entry_t side_sample(bit on_right, bit engaged);
        entry_t     e;
        logic [7:0] lvl;
        logic       prs;
        e = any_entry();
        e.gap_us = pick_gap();
        if (engaged)
        begin
            if ($urandom_range(1))
            begin
                lvl = $urandom_range(board.thr, 255);
                prs = $urandom_range(1);
            end
            else
            begin
                lvl = $urandom_range(255);
                prs = 1'b1;
            end
        end
        else
        begin
            lvl = quiet_level();
            prs = 1'b0;
        end
        if (on_right)
        begin
            e.level_right = lvl;
            e.press_right = prs;
        end
        else
        begin
            e.level_left = lvl;
            e.press_left = prs;
        end
        return e;
    endfunction

    // Mostly inside the capture, some anywhere, some right at the boundary.
    function automatic logic [IDX_W-1:0] pick_index();
        int roll;
        int n;
        roll = $urandom_range(99);
        n = board.fill_count;
        if (roll < 60 && n > 0)
            return $urandom_range(0, n - 1);
        else if (roll < 85)
            return $urandom_range(1023);
        else if (n > 1023)
            return 10'd1023;
        else if ($urandom_range(1) && n > 0)
            return n - 1;
        else
            return n;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic c, input logic frz, input entry_t e,
                             input logic [IDX_W-1:0] idx);
        while (!calm && $urandom_range(99) < 34)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        cmd         <= c;
        freeze      <= frz;
        level_left  <= e.level_left;
        level_right <= e.level_right;
        press_left  <= e.press_left;
        press_right <= e.press_right;
        gap_us      <= e.gap_us;
        read_index  <= idx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!(c == CMD_SAMPLE && frz))
            live_beats++;
    endtask

    task automatic sample(input logic [7:0] ll, input logic [7:0] lr, input logic pl,
                          input logic pr, input logic [15:0] g);
        send_beat(CMD_SAMPLE, 1'b0, make_entry(ll, lr, pl, pr, g), $urandom_range(1023));
    endtask

    task automatic read_entry(input logic [IDX_W-1:0] idx);
        send_beat(CMD_READ, $urandom_range(1), any_entry(), idx);
    endtask

    // Sample beat with occasional reads, frozen copies and plain noise mixed in.
    task automatic offer(input entry_t e);
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            read_entry(pick_index());
        else if (roll < 17)
            send_beat(CMD_SAMPLE, 1'b1, any_entry(), $urandom_range(1023));
        else if (roll < 22)
            e = any_entry();
        send_beat(CMD_SAMPLE, 1'b0, e, $urandom_range(1023));
    endtask

    // Sender pause: wait out every status beat due, then the trigger copy.
    // One edge first so the monitor has noted the last accepted beat.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_sel_t sel, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic [7:0] thr, input logic [19:0] hold);
        settle();
        write_reg(REG_THRESHOLD, {12'd0, thr});
        write_reg(REG_HOLD, hold);
    endtask

    // One capture life: quiet lead-in, trigger, held run, release run.
    task automatic run_episode();
        bit on_right;
        int n;
        entry_t e;
        n = $urandom_range(0, 24);
        for (int k = 0; k < n; k++)
        begin
            e = side_sample(1'b0, 1'b0);
            e.level_right = quiet_level();
            e.press_right = 1'b0;
            offer(e);
        end
        on_right = $urandom_range(1);
        e = side_sample(on_right, 1'b1);
        if (on_right)
        begin
            e.level_left = quiet_level();
            e.press_left = 1'b0;
        end
        offer(e);
        n = $urandom_range(0, 12);
        for (int k = 0; k < n; k++)
            offer(side_sample(on_right, 1'b1));
        // An occasional engaged sample in the release run restarts the hold timer.
        for (int k = 0; k < 40 && board.active; k++)
            offer(side_sample(on_right, $urandom_range(99) < 8));
    endtask

    task automatic run_random(input int quota);
        int start;
        start = live_beats;
        while (live_beats - start < quota)
            run_episode();
    endtask

    // Status at reset, boundaries of both levels, both sides, side priority,
    // frozen beats, reads in and out of range, hold timer reset and expiry.
    task automatic run_directed();
        read_entry(10'd1023);
        send_beat(CMD_READ, 1'b1, make_entry(8'd0, 8'd0, 1'b0, 1'b0, 16'd0), 10'd0);
        sample(8'd0, 8'd0, 1'b0, 1'b0, 16'd0);
        sample(8'd42, 8'd42, 1'b0, 1'b0, 16'hFFFF);
        send_beat(CMD_SAMPLE, 1'b1, make_entry(8'd255, 8'd255, 1'b1, 1'b1, 16'hFFFF),
                  10'd1023);
        sample(8'd43, 8'd0, 1'b0, 1'b0, 16'd1234);     // left at threshold
        read_entry(10'd0);
        read_entry(10'd19);
        read_entry(10'd20);
        read_entry(10'd1023);
        sample(8'd0, 8'd255, 1'b1, 1'b0, 16'd77);      // held by press alone
        sample(8'd42, 8'd0, 1'b0, 1'b1, 16'd19999);    // release, timer just short
        sample(8'd0, 8'd0, 1'b0, 1'b0, 16'd1);         // timer reaches hold
        read_entry(10'd21);
        read_entry(10'd22);
        sample(8'd0, 8'd43, 1'b0, 1'b0, 16'd500);      // right at threshold
        sample(8'd255, 8'd0, 1'b0, 1'b0, 16'hFFFF);    // left level ignored on right
        sample(8'd0, 8'd0, 1'b0, 1'b1, 16'd10);        // right by press
        sample(8'd0, 8'd42, 1'b0, 1'b0, 16'd0);
        sample(8'd0, 8'd200, 1'b0, 1'b0, 16'd30000);   // held again, timer cleared
        sample(8'd0, 8'd0, 1'b0, 1'b0, 16'hFFFF);
        sample(8'd255, 8'd255, 1'b1, 1'b1, 16'hFFFF);  // both sides: left wins
        sample(8'd0, 8'd0, 1'b0, 1'b0, 16'hFFFF);
        read_entry(10'd0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        cmd          = CMD_SAMPLE;
        freeze       = 1'b0;
        level_left   = '0;
        level_right  = '0;
        press_left   = 1'b0;
        press_right  = 1'b0;
        gap_us       = '0;
        read_index   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_THRESHOLD;
        cfg_data     = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        live_beats   = 0;
        cycles       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Zero threshold: every sample triggers or holds, so one long capture
        // runs; back-to-back beats on both sides here.
        set_mode(8'd0, $urandom_range(1000000));
        calm = 1'b1;
        for (int k = 0; k < 250; k++)
        begin
            if ($urandom_range(99) < 8)
                read_entry(pick_index());
            else
                send_beat(CMD_SAMPLE, $urandom_range(99) < 3, any_entry(),
                          $urandom_range(1023));
        end
        settle();
        calm = 1'b0;

        set_mode(8'd255, 20'd0);                 // top threshold, zero hold
        run_random(60);
        set_mode($urandom_range(255), 20'd1000000);
        hold_off_req = 1'b1;                     // pop side stalls, push side keeps going
        run_random(60);
        set_mode(8'd1, 20'd65535);
        run_random(60);
        set_mode($urandom_range(255), $urandom_range(1000000));
        run_random(60);
        set_mode($urandom_range(255), $urandom_range(3000));
        run_random(60);
        set_mode(8'd200, 20'd1);
        run_random(60);

        settle();
        if (board.faults == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pce_pkg.sv
hdl/pce_front.sv
hdl/pce_queue.sv
hdl/pce_back.sv
hdl/pretrigger_capture_engine.sv
bench/pretrigger_capture_engine_test.sv
